// File: design/etc_pkg.sv
// ----------------------------------------------------------------------------
// etc_pkg - shared types and constants for the epoch-to-calendar core
// Reciprocal constants for the constant divisions, stage payload types and
// the month-start table of the March-based year.
// ----------------------------------------------------------------------------
package etc_pkg;

    // time of day plus whole days since 1970-01-01
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [15:0] days;
    } tod_t;

    // full calendar result
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  min;
        logic [5:0]  sec;
    } cal_t;

    // x / 60 = (x * RECIP_60) >> SH_60, exact for any 32-bit x
    localparam logic [31:0] RECIP_60   = 32'h8888_8889;
    localparam int          SH_60      = 37;
    // x / 3, exact for x below 2^19
    localparam logic [17:0] RECIP_3    = 18'd174763;
    localparam int          SH_3       = 19;
    // x / 7, exact for x below 349525
    localparam logic [17:0] RECIP_7    = 18'd149797;
    localparam int          SH_7       = 20;
    // x / 1461, exact for x below 94519
    localparam logic [15:0] RECIP_1461 = 16'd45934;
    localparam int          SH_1461    = 26;
    // x / 365, exact for x below 15196
    localparam logic [11:0] RECIP_365  = 12'd2873;
    localparam int          SH_365     = 20;
    // x / 153, exact for x below 12192
    localparam logic [12:0] RECIP_153  = 13'd6854;
    localparam int          SH_153     = 20;

    // days from 1968-03-01 to 1970-01-01
    localparam logic [16:0] DAY_OFFSET  = 17'd671;
    // shifted day index of 2100-03-01; 2100 has no 29 February
    localparam logic [16:0] CENTURY_GAP = 17'd48212;
    localparam logic [11:0] BASE_YEAR   = 12'd1968;

    // first day of each month of a year that starts on 1 March
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

// File: design/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core - seconds since 1970 to Gregorian date/time
// Ten-stage pipeline: time of day, then weekday, year, month and day.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (lowest bit up)
// s_      | in  | epoch_seconds[31:0]
// m_      | out | sec, min, hour, weekday, day, month, year, zero fill
//
// One beat per cycle sustained while m_tready stays high; m_tvalid rises
// once the s_ beat has passed four time-of-day and six date stages.
// Each stage holds its own valid bit, so a stall on m_ fills empty stages
// before s_tready drops; nothing is lost or repeated.
// aresetn clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [5:0] sec_of_minute, [11:6] min_of_hour,
                                   // [16:12] hour_of_day, [19:17] weekday,
                                   // [24:20] day_of_month, [28:25] month_number,
                                   // [40:29] year_number, [47:41] zero
);

    logic          tod_valid;
    logic          tod_ready;
    etc_pkg::tod_t tod;
    etc_pkg::cal_t cal;

    etc_tod u_tod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_secs   (s_tdata),
        .out_valid (tod_valid),
        .out_ready (tod_ready),
        .out_tod   (tod)
    );

    etc_date u_date (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tod_valid),
        .in_ready  (tod_ready),
        .in_tod    (tod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cal   (cal)
    );

    // pack result beat
    assign m_tdata = {7'd0, cal.year, cal.month, cal.day, cal.weekday,
                      cal.hour, cal.min, cal.sec};

endmodule

// File: design/etc_tod.sv
// ----------------------------------------------------------------------------
// etc_tod - time-of-day pipeline
// Four stages split the seconds count into second, minute, hour and days
// by reciprocal multiplication; every stage but the last forms one product.
// ----------------------------------------------------------------------------
module etc_tod (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_secs,
    output logic                out_valid,
    input  logic                out_ready,
    output etc_pkg::tod_t       out_tod
);

    localparam int NST = 4;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    // stage registers
    logic [31:0] t1_reg;
    logic [63:0] p1_reg;
    logic [26:0] q1_reg;
    logic [5:0]  sec2_reg;
    logic [58:0] p2_reg;
    logic [20:0] q2_reg;
    logic [5:0]  sec3_reg;
    logic [5:0]  min3_reg;
    logic [35:0] p3_reg;
    etc_pkg::tod_t tod4_reg;

    logic [26:0] q1;
    logic [31:0] rem1;
    logic [20:0] q2;
    logic [26:0] rem2;
    logic [15:0] dq;
    logic [20:0] rem3;

    // a stage loads when it is empty or its successor is loading
    always_comb begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign out_tod   = tod4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // quotient / remainder arithmetic
    always_comb begin
        q1   = p1_reg[63:etc_pkg::SH_60];
        rem1 = t1_reg - 32'(q1) * 32'd60;
        q2   = p2_reg[57:etc_pkg::SH_60];
        rem2 = q1_reg - 27'(q2) * 27'd60;
        dq   = p3_reg[34:etc_pkg::SH_3];
        rem3 = q2_reg - 21'(dq) * 21'd24;
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t1_reg <= in_secs;
            p1_reg <= 64'(in_secs) * 64'(etc_pkg::RECIP_60);
        end
        if (en[1]) begin
            q1_reg   <= q1;
            sec2_reg <= rem1[5:0];
            p2_reg   <= 59'(q1) * 59'(etc_pkg::RECIP_60);
        end
        if (en[2]) begin
            q2_reg   <= q2;
            sec3_reg <= sec2_reg;
            min3_reg <= rem2[5:0];
            p3_reg   <= 36'(q2[20:3]) * 36'(etc_pkg::RECIP_3);
        end
        if (en[3]) begin
            tod4_reg.sec  <= sec3_reg;
            tod4_reg.min  <= min3_reg;
            tod4_reg.hour <= rem3[4:0];
            tod4_reg.days <= dq;
        end
    end

endmodule

// File: design/etc_date.sv
// ----------------------------------------------------------------------------
// etc_date - calendar date pipeline
// Six stages turn the day count into weekday, day, month and year using
// four-year cycles counted from 1968-03-01, with 2100 fixed up.
// ----------------------------------------------------------------------------
module etc_date (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  etc_pkg::tod_t       in_tod,
    output logic                out_valid,
    input  logic                out_ready,
    output etc_pkg::cal_t       out_cal
);

    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    etc_pkg::tod_t tod1_reg, tod2_reg, tod3_reg, tod4_reg, tod5_reg;
    logic [15:0] z1_reg, z2_reg;
    logic [34:0] p4_reg;
    logic [31:0] p5_reg;
    logic [2:0]  dow2_reg, dow3_reg, dow4_reg, dow5_reg;
    logic [5:0]  c2_reg, c3_reg, c4_reg, c5_reg;
    logic [10:0] r3_reg;
    logic [22:0] p6_reg;
    logic [1:0]  yoe4_reg, yoe5_reg;
    logic [8:0]  doy4_reg, doy5_reg;
    logic [23:0] p7_reg;
    etc_pkg::cal_t cal_reg;

    logic [16:0] z0, zs;
    logic [16:0] d3;
    logic [12:0] wq;
    logic [16:0] wrem;
    logic [15:0] rr;
    logic [2:0]  yq;
    logic [1:0]  yoe;
    logic [10:0] doy_w;
    logic [10:0] mnum;
    logic [3:0]  mp;
    logic [8:0]  dom;
    logic [3:0]  mon;
    logic [11:0] yr;

    // a stage loads when it is empty or its successor is loading
    always_comb begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign out_cal   = cal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_comb begin
        // shift to a March-based day index, skipping 29 February 2100
        z0 = 17'(in_tod.days) + etc_pkg::DAY_OFFSET;
        zs = (z0 >= etc_pkg::CENTURY_GAP) ? z0 + 17'd1 : z0;
        d3 = 17'(in_tod.days) + 17'd3;
        // weekday: 1970-01-01 was a Thursday
        wq   = p4_reg[32:etc_pkg::SH_7];
        wrem = 17'(tod1_reg.days) + 17'd3 - 17'(wq) * 17'd7;
        // day within the four-year cycle
        rr = z2_reg - 16'(c2_reg) * 16'd1461;
        // year within the cycle, last day of a cycle capped at three
        yq    = p6_reg[22:etc_pkg::SH_365];
        yoe   = (yq > 3'd3) ? 2'd3 : yq[1:0];
        doy_w = r3_reg - 11'(yoe) * 11'd365;
        mnum  = 11'(doy4_reg) * 11'd5 + 11'd2;
        // month, day and year
        mp  = p7_reg[23:etc_pkg::SH_153];
        dom = doy5_reg - etc_pkg::month_start(mp) + 9'd1;
        mon = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        yr  = etc_pkg::BASE_YEAR + {4'd0, c5_reg, 2'b00} + 12'(yoe5_reg)
              + ((mon <= 4'd2) ? 12'd1 : 12'd0);
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tod1_reg <= in_tod;
            z1_reg   <= zs[15:0];
            p4_reg   <= 35'(d3) * 35'(etc_pkg::RECIP_7);
            p5_reg   <= 32'(zs[15:0]) * 32'(etc_pkg::RECIP_1461);
        end
        if (en[1]) begin
            tod2_reg <= tod1_reg;
            dow2_reg <= wrem[2:0] + 3'd1;
            z2_reg   <= z1_reg;
            c2_reg   <= p5_reg[31:etc_pkg::SH_1461];
        end
        if (en[2]) begin
            tod3_reg <= tod2_reg;
            dow3_reg <= dow2_reg;
            c3_reg   <= c2_reg;
            r3_reg   <= rr[10:0];
            p6_reg   <= 23'(rr[10:0]) * 23'(etc_pkg::RECIP_365);
        end
        if (en[3]) begin
            tod4_reg <= tod3_reg;
            dow4_reg <= dow3_reg;
            c4_reg   <= c3_reg;
            yoe4_reg <= yoe;
            doy4_reg <= doy_w[8:0];
        end
        if (en[4]) begin
            tod5_reg <= tod4_reg;
            dow5_reg <= dow4_reg;
            c5_reg   <= c4_reg;
            yoe5_reg <= yoe4_reg;
            doy5_reg <= doy4_reg;
            p7_reg   <= 24'(mnum) * 24'(etc_pkg::RECIP_153);
        end
        if (en[5]) begin
            cal_reg.sec     <= tod5_reg.sec;
            cal_reg.min     <= tod5_reg.min;
            cal_reg.hour    <= tod5_reg.hour;
            cal_reg.weekday <= dow5_reg;
            cal_reg.day     <= dom[4:0];
            cal_reg.month   <= mon;
            cal_reg.year    <= yr;
        end
    end

endmodule

// File: design/etc_checker.sv
// ----------------------------------------------------------------------------
// etc_checker - port-level checks for the epoch-to-calendar core
// Watches both channels for held beats and the result for legal field ranges.
// ----------------------------------------------------------------------------
module etc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input beat changed under stall");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // time of day in range
    a_tod: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:0] < 6'd60 && m_tdata[11:6] < 6'd60
                     && m_tdata[16:12] < 5'd24)
        else $error("time of day out of range");

    // date fields in range
    a_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:17] != 3'd0 && m_tdata[24:20] != 5'd0
                     && m_tdata[28:25] != 4'd0 && m_tdata[28:25] <= 4'd12
                     && m_tdata[40:29] >= 12'd1970 && m_tdata[40:29] <= 12'd2106)
        else $error("date out of range");

    // pipeline empty straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind epoch_seconds_to_calendar_core etc_checker u_etc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/tb_epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_core - seconds-to-calendar core testbench
// Streams epoch second counts into the core with random gaps, predicts the
// calendar date and time of each beat with an independent year and month
// walk, and compares every output beat field by field in order.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  min;
        logic [5:0]  sec;
    } date_fields_t;

    localparam int LATENCY = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic [31:0]  pending_secs[$];
    date_fields_t expected_dates[$];
    int           error_count = 0;
    bit           hold_sender = 1'b0;
    bit           stimulus_done = 1'b0;
    int           send_gap = 0;
    int           recv_gap = 0;

    epoch_seconds_to_calendar_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // calendar conversion by walking whole years then months
    function automatic date_fields_t to_calendar(logic [31:0] secs);
        date_fields_t d;
        int unsigned  t;
        int unsigned  yr;
        int unsigned  mo;
        int unsigned  len;
        t = secs;
        d.sec = 6'(t % 60);  t = t / 60;
        d.min = 6'(t % 60);  t = t / 60;
        d.hour = 5'(t % 24); t = t / 24;
        d.weekday = 3'(((t + 3) % 7) + 1);
        yr = 1970;
        forever begin
            len = leap_year(yr) ? 366 : 365;
            if (t < len) break;
            t -= len;
            yr++;
        end
        mo = 1;
        while (mo < 12) begin
            case (mo)
                2:             len = leap_year(yr) ? 29 : 28;
                4, 6, 9, 11:   len = 30;
                default:       len = 31;
            endcase
            if (t < len) break;
            t -= len;
            mo++;
        end
        d.day = 5'(t + 1);
        d.month = 4'(mo);
        d.year = 12'(yr);
        return d;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // driver: one beat per handshake, random gap lengths between beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_dates.push_back(to_calendar(s_tdata));
                send_gap = gap_length();
            end
            if ((!s_tvalid || s_tready) ) begin
                if (send_gap > 0 || hold_sender || pending_secs.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_secs.pop_front();
                end
            end
        end
    end

    // monitor: random back-pressure and in-order comparison
    always @(posedge aclk) begin
        date_fields_t got;
        date_fields_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[40:0];
                if (expected_dates.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_dates.pop_front();
                    if (got.sec != want.sec)
                        report_mismatch("sec", int'(got.sec), int'(want.sec));
                    if (got.min != want.min)
                        report_mismatch("min", int'(got.min), int'(want.min));
                    if (got.hour != want.hour)
                        report_mismatch("hour", int'(got.hour), int'(want.hour));
                    if (got.weekday != want.weekday)
                        report_mismatch("weekday", int'(got.weekday), int'(want.weekday));
                    if (got.day != want.day)
                        report_mismatch("day", int'(got.day), int'(want.day));
                    if (got.month != want.month)
                        report_mismatch("month", int'(got.month), int'(want.month));
                    if (got.year != want.year)
                        report_mismatch("year", int'(got.year), int'(want.year));
                    if (m_tdata[47:41] != '0)
                        report_mismatch("fill", int'(m_tdata[47:41]), 0);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = gap_length();
            end
        end
    end

    // stimulus
    initial begin
        int unsigned y;
        int unsigned start_day;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: epoch start, extremes, leap days, century year
        pending_secs.push_back(32'd0);
        pending_secs.push_back(32'hFFFF_FFFF);
        pending_secs.push_back(32'hFFFF_FFFE);
        pending_secs.push_back(32'h8000_0000);
        pending_secs.push_back(32'h7FFF_FFFF);
        pending_secs.push_back(32'h5555_5555);
        pending_secs.push_back(32'hAAAA_AAAA);
        pending_secs.push_back(32'd86399);
        pending_secs.push_back(32'd86400);
        pending_secs.push_back(32'd68169599);   // 1972-02-28 23:59:59
        pending_secs.push_back(32'd68169600);   // 1972-02-29
        pending_secs.push_back(32'd951782400);  // 2000-02-29
        pending_secs.push_back(32'd951868800);  // 2000-03-01
        pending_secs.push_back(32'd4107542399); // 2100-02-28 23:59:59
        pending_secs.push_back(32'd4107542400); // 2100-03-01, no leap day
        pending_secs.push_back(32'd4102444799); // 2099-12-31 23:59:59
        pending_secs.push_back(32'd31535999);   // 1970-12-31 23:59:59
        pending_secs.push_back(32'd31536000);   // 1971-01-01
        // hold off until the pipeline drains
        wait (pending_secs.size() == 0);
        hold_sender = 1'b1;
        wait (!s_tvalid && expected_dates.size() == 0);
        @(posedge aclk);
        hold_sender = 1'b0;
        // random: mostly uniform, some near year and month boundaries
        for (int i = 0; i < 450; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                y = $urandom_range(0, 135);
                start_day = y * 365 + (y + 1) / 4 - (y > 130 ? 1 : 0);
                pending_secs.push_back(start_day * 86400 + $urandom_range(0, 86400 * 62)
                                       - 86400 * $urandom_range(0, 1));
            end else begin
                pending_secs.push_back($urandom());
            end
            if (pending_secs.size() > 20) wait (pending_secs.size() < 5);
        end
        wait (pending_secs.size() == 0 && !s_tvalid);
        wait (expected_dates.size() == 0);
        repeat (LATENCY * 4) @(posedge aclk);
        stimulus_done = 1'b1;
        if (error_count == 0 && expected_dates.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        if (!stimulus_done) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
